@@ rtl/core/prd_pkg.sv @@
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants for the pulse rate detector
// ----------------------------------------------------------------------------
package prd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ALPHA     = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_MIN_INT   = 3'd2;
  localparam logic [2:0] REG_MAX_INT   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;

  // register reset values
  localparam logic [16:0] ALPHA_RST     = 17'd13107;
  localparam logic [17:0] THRESHOLD_RST = 18'd256;
  localparam logic [15:0] MIN_INT_RST   = 16'd300;
  localparam logic [15:0] MAX_INT_RST   = 16'd2000;
  localparam logic [15:0] TIMEOUT_RST   = 16'd3000;

  // alpha of one in Q1.16
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // beats per minute from an interval in ms
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [7:0]  BPM_SAT    = 8'd255;

  // one count in Q10.8, added to the low value for a flat window
  localparam logic [18:0] FLAT_SPAN = 19'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_UPD,
    ST_PEAK,
    ST_DIV,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/core/pulse_rate_detector.sv @@
// ----------------------------------------------------------------------------
// pulse_rate_detector
// Low-pass filter, slope peak detector and window min/max over pulse samples
// ----------------------------------------------------------------------------
// One item is taken at a time. A sample while measuring passes through the
// filter and peak step (one multiply), the scan set-up, the min/max scan of
// the N filled window entries (WINDOW_DEPTH once full), the scan drain, the
// result load and the idle state that takes the next item. A peak that yields
// a new interval adds a bit-serial divide of 60000 before the scan set-up.
// The min/max scan, one entry a cycle through the single read port of the
// history memory, dominates the time per item. A toggle or a sample while
// stopped skips the filter and costs the scan alone. The finished result
// sits in an output register, so the next item may be taken while it waits
// for its transfer; a result that is still waiting there holds the following
// one in its last state. Unwritten history entries count as zero through a
// fill count, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module pulse_rate_detector
  import prd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,

  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_wdata,

  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [9:0]  in_sample,
  input  logic [31:0] in_time_ms,

  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running,
  output logic [7:0]  out_rate_bpm,
  output logic [17:0] out_smoothed,
  output logic [17:0] out_window_low,
  output logic [18:0] out_window_high
);

  localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNTW = $clog2(WINDOW_DEPTH + 1);

  // configuration
  logic [16:0] alpha_r;
  logic [17:0] thr_r;
  logic [15:0] min_int_r;
  logic [15:0] max_int_r;
  logic [15:0] timeout_r;

  // sequencer
  state_t state_r, state_nxt;

  // detector state
  logic        active_r;
  logic [17:0] filtered_r;
  logic [17:0] prev_r;
  logic [7:0]  beats_r;
  logic [31:0] last_peak_r;
  logic        await_r;

  // item held while it is worked on
  logic [9:0]  sample_r;
  logic [31:0] time_r;

  // filter product
  logic signed [36:0] prod_r;

  // divider
  logic [15:0] dvd_r;
  logic [15:0] dsr_r;
  logic [15:0] rem_r;
  logic [3:0]  div_cnt_r;

  // history window
  logic [17:0]     hist_mem [WINDOW_DEPTH];
  logic [17:0]     rd_data_r;
  logic [AW-1:0]   wp_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] ra_r;
  logic            rv_r;
  logic [17:0]     lo_r;
  logic [17:0]     hi_r;
  logic            seen_r;

  // output register
  logic        out_valid_r;
  logic        out_running_r;
  logic [7:0]  out_bpm_r;
  logic [17:0] out_smoothed_r;
  logic [17:0] out_low_r;
  logic [18:0] out_high_r;

  // control strobes
  logic in_xfer;
  logic hist_we;
  logic out_load;

  // shared datapath terms
  logic [16:0]        alpha_sat;
  logic signed [18:0] filt_diff;
  logic [20:0]        filt_sum;
  logic [17:0]        filt_new;
  logic signed [19:0] delta;
  logic signed [19:0] thr_s;
  logic               rise;
  logic               fall;
  logic [31:0]        interval;
  logic               div_go;
  logic [31:0]        since_peak;
  logic [16:0]        div_trial;
  logic               div_bit;
  logic               scan_done;
  logic               scan_issue;
  logic [18:0]        high_fix;

  // --------------------------------------------------------------------------
  // arithmetic
  // --------------------------------------------------------------------------

  // a*x + (1-a)*f == f + a*(x - f): a single signed multiply, floor by shift
  assign alpha_sat = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign filt_diff = $signed({1'b0, sample_r, 8'b0}) - $signed({1'b0, filtered_r});
  assign filt_sum  = {3'b000, filtered_r} + prod_r[36:16];
  assign filt_new  = filt_sum[17:0];

  // slope against the previous filtered value
  assign delta = $signed({2'b00, filtered_r}) - $signed({2'b00, prev_r});
  assign thr_s = $signed({2'b00, thr_r});
  assign rise  = !await_r && (delta > thr_s);
  assign fall  = await_r && (delta < -thr_s);

  // interval to the previous peak, only with a peak on record
  assign interval = time_r - last_peak_r;
  assign div_go   = rise && (last_peak_r != 32'd0) &&
                    (interval > {16'd0, min_int_r}) &&
                    (interval < {16'd0, max_int_r});
  assign since_peak = time_r - last_peak_r;

  // restoring divide, one quotient bit a cycle
  assign div_trial = {rem_r, dvd_r[15]};
  assign div_bit   = div_trial >= {1'b0, dsr_r};

  // scan over the filled part of the window
  assign scan_issue = ra_r < cnt_r;
  assign scan_done  = !scan_issue && !rv_r;
  assign high_fix   = (hi_r == lo_r) ? ({1'b0, lo_r} + FLAT_SPAN) : {1'b0, hi_r};

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (!in_mode && active_r) ? ST_FILT : ST_SCAN_INIT;
        end
      end
      ST_FILT:      state_nxt = ST_UPD;
      ST_UPD:       state_nxt = ST_PEAK;
      ST_PEAK:      state_nxt = div_go ? ST_DIV : ST_SCAN_INIT;
      ST_DIV: begin
        if (div_cnt_r == 4'd15) begin
          state_nxt = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    in_xfer  = in_valid && (state_r == ST_IDLE);
    hist_we  = (state_r == ST_UPD);
    out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= ALPHA_RST;
      thr_r     <= THRESHOLD_RST;
      min_int_r <= MIN_INT_RST;
      max_int_r <= MAX_INT_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ALPHA:     alpha_r   <= cfg_wdata[16:0];
        REG_THRESHOLD: thr_r     <= cfg_wdata;
        REG_MIN_INT:   min_int_r <= cfg_wdata[15:0];
        REG_MAX_INT:   max_int_r <= cfg_wdata[15:0];
        REG_TIMEOUT:   timeout_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // detector state: filter, peak logic and divider
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      filtered_r  <= '0;
      prev_r      <= '0;
      beats_r     <= '0;
      last_peak_r <= '0;
      await_r     <= 1'b0;
      wp_r        <= '0;
      cnt_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          // toggle clears the peak tracking but keeps filter and window
          if (in_xfer && in_mode) begin
            active_r    <= !active_r;
            beats_r     <= '0;
            last_peak_r <= '0;
            await_r     <= 1'b0;
          end
        end
        ST_UPD: begin
          filtered_r <= filt_new;
          wp_r       <= (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          if (cnt_r != CNTW'(WINDOW_DEPTH)) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_PEAK: begin
          prev_r <= filtered_r;
          if (rise) begin
            await_r     <= 1'b1;
            last_peak_r <= time_r;
          end else begin
            if (fall) begin
              await_r <= 1'b0;
            end
            // a fresh peak leaves zero elapsed time, so only here
            if (since_peak > {16'd0, timeout_r}) begin
              beats_r <= '0;
            end
          end
        end
        ST_DIV: begin
          // quotient above 255 saturates
          if (div_cnt_r == 4'd15) begin
            beats_r <= ({dvd_r[14:0], div_bit} > {8'd0, BPM_SAT}) ?
                       BPM_SAT : {dvd_r[6:0], div_bit};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item capture, product and divider datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_sample;
      time_r   <= in_time_ms;
    end
    if (state_r == ST_FILT) begin
      prod_r <= $signed({1'b0, alpha_sat}) * filt_diff;
    end
    if (state_r == ST_PEAK) begin
      dvd_r     <= MS_PER_MIN;
      dsr_r     <= interval[15:0];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r     <= div_bit ? 16'(div_trial - {1'b0, dsr_r}) : div_trial[15:0];
      dvd_r     <= {dvd_r[14:0], div_bit};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // history memory and min/max scan
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= filt_new;
    end
    rd_data_r <= hist_mem[ra_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      ra_r <= '0;
    end else if (state_r == ST_SCAN_INIT) begin
      rv_r <= 1'b0;
      ra_r <= '0;
    end else if (state_r == ST_SCAN) begin
      rv_r <= scan_issue;
      if (scan_issue) begin
        ra_r <= ra_r + 1'b1;
      end
    end
  end

  // entries never written count as zero: while filling, the scan is seeded with zero
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN_INIT) begin
      lo_r   <= '0;
      hi_r   <= '0;
      seen_r <= (cnt_r != CNTW'(WINDOW_DEPTH));
    end else if (state_r == ST_SCAN && rv_r) begin
      seen_r <= 1'b1;
      if (!seen_r || rd_data_r < lo_r) begin
        lo_r <= rd_data_r;
      end
      if (!seen_r || rd_data_r > hi_r) begin
        hi_r <= rd_data_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_running_r  <= active_r;
      out_bpm_r      <= beats_r;
      out_smoothed_r <= filtered_r;
      out_low_r      <= lo_r;
      out_high_r     <= high_fix;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_running     = out_running_r;
  assign out_rate_bpm    = out_bpm_r;
  assign out_smoothed    = out_smoothed_r;
  assign out_window_low  = out_low_r;
  assign out_window_high = out_high_r;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pulse rate detector: a queue-fed driver, a
// monitor that compares every result with a cycle-free predictor of the
// filter, the slope peak detector and the window min/max, random idling on
// both channels, one long output hold-off and several register settings
// ----------------------------------------------------------------------------
module testbench
  import prd_pkg::*;
;

  localparam int DEPTH       = 128;
  // long output hold-off, and the watchdog limit on cycles with no transfer
  localparam int HOLD_CYCLES = 800;
  localparam int LIMIT       = 4000;

  typedef struct packed {
    logic        mode;
    logic [9:0]  sample;
    logic [31:0] time_ms;
  } pulse_item_t;

  typedef struct packed {
    logic        running;
    logic [7:0]  rate_bpm;
    logic [17:0] smoothed;
    logic [17:0] window_low;
    logic [18:0] window_high;
  } pulse_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [9:0]  in_sample = '0;
  logic [31:0] in_time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_running;
  logic [7:0]  out_rate_bpm;
  logic [17:0] out_smoothed;
  logic [17:0] out_window_low;
  logic [18:0] out_window_high;

  pulse_rate_detector #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_sample(in_sample), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_running(out_running),
    .out_rate_bpm(out_rate_bpm), .out_smoothed(out_smoothed),
    .out_window_low(out_window_low), .out_window_high(out_window_high)
  );

  always #5 clk = ~clk;

  // items waiting for the driver, and reports waiting for the monitor
  pulse_item_t   queued_items[$];
  pulse_report_t awaited_reports[$];
  int            errors = 0;
  int            item_total = 0;

  // shadow registers
  logic [16:0] alpha_q;
  logic [17:0] slope_thr;
  logic [15:0] min_gap_ms;
  logic [15:0] max_gap_ms;
  logic [15:0] stale_ms;

  // shadow detector state
  logic        det_active;
  logic [17:0] det_filtered;
  logic [17:0] det_prev;
  logic [7:0]  det_beats;
  logic [31:0] det_last_peak;
  logic        det_awaiting;
  logic [17:0] smooth_hist [DEPTH];
  int          win_pos;

  // stimulus-side view: running flag and the running timestamp
  logic        gen_running = 1'b0;
  logic [31:0] gen_time = '0;

  // handshake bookkeeping
  logic        offering = 1'b0;
  int          in_gap = 0;
  int          out_wait = 0;
  int          hold_left = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  logic        calm_in = 1'b0;
  logic        calm_out = 1'b0;
  int          idle_cycles = 0;

  task automatic reset_detector();
    alpha_q       = ALPHA_RST;
    slope_thr     = THRESHOLD_RST;
    min_gap_ms    = MIN_INT_RST;
    max_gap_ms    = MAX_INT_RST;
    stale_ms      = TIMEOUT_RST;
    det_active    = 1'b0;
    det_filtered  = '0;
    det_prev      = '0;
    det_beats     = '0;
    det_last_peak = '0;
    det_awaiting  = 1'b0;
    for (int i = 0; i < DEPTH; i++) smooth_hist[i] = '0;
    win_pos = 0;
  endtask

  // works out the report for one accepted item and files it
  task automatic advance_detector(input logic mode, input logic [9:0] raw,
                                  input logic [31:0] now);
    logic [16:0]   a_sat;
    logic [63:0]   a64, r64, f64, acc;
    logic [31:0]   interval, q, per_min;
    logic [17:0]   lo, hi18;
    int            fi, pi, thr, delta;
    pulse_report_t r;
    if (mode) begin
      det_active    = !det_active;
      det_beats     = '0;
      det_last_peak = '0;
      det_awaiting  = 1'b0;
    end else if (det_active) begin
      // low-pass filter, alpha saturated at one
      a_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
      a64 = 64'(a_sat);
      r64 = 64'(raw);
      r64 = r64 << 8;
      f64 = 64'(det_filtered);
      acc = a64 * r64 + (64'd65536 - a64) * f64;
      det_filtered = acc[33:16];
      smooth_hist[win_pos] = det_filtered;
      win_pos = (win_pos + 1) % DEPTH;
      // slope peak step
      fi = int'(det_filtered);
      pi = int'(det_prev);
      thr = int'(slope_thr);
      delta = fi - pi;
      det_prev = det_filtered;
      if (!det_awaiting && delta > thr) begin
        det_awaiting = 1'b1;
        // a peak stamped at zero reads as no peak
        if (det_last_peak != 32'd0) begin
          interval = now - det_last_peak;
          if (interval > 32'(min_gap_ms) && interval < 32'(max_gap_ms)) begin
            per_min = 32'(MS_PER_MIN);
            q = per_min / interval;
            det_beats = (q > 32'(BPM_SAT)) ? BPM_SAT : q[7:0];
          end
        end
        det_last_peak = now;
      end else if (det_awaiting && delta < -thr) begin
        det_awaiting = 1'b0;
      end
      interval = now - det_last_peak;
      if (interval > 32'(stale_ms)) det_beats = '0;
    end
    lo   = smooth_hist[0];
    hi18 = smooth_hist[0];
    for (int i = 1; i < DEPTH; i++) begin
      if (smooth_hist[i] < lo) lo = smooth_hist[i];
      if (smooth_hist[i] > hi18) hi18 = smooth_hist[i];
    end
    r.running     = det_active;
    r.rate_bpm    = det_beats;
    r.smoothed    = det_filtered;
    r.window_low  = lo;
    // flat window reports one count of span
    r.window_high = (hi18 == lo) ? ({1'b0, lo} + FLAT_SPAN) : {1'b0, hi18};
    awaited_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------- driver
  // offers queued items, waits its drawn gap after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      in_gap   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_detector(in_mode, in_sample, in_time_ms);
        offering = 1'b0;
        in_gap   = calm_in ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (queued_items.size() != 0) begin
          pulse_item_t it;
          it = queued_items.pop_front();
          in_mode    <= it.mode;
          in_sample  <= it.sample;
          in_time_ms <= it.time_ms;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // --------------------------------------------------------------- monitor
  // checks each result transfer, then stalls for its drawn count or a hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("result transfer with no report awaited");
          errors++;
        end else begin
          pulse_report_t want;
          want = awaited_reports.pop_front();
          check_field("running", 32'(want.running), 32'(out_running));
          check_field("rate_bpm", 32'(want.rate_bpm), 32'(out_rate_bpm));
          check_field("smoothed", 32'(want.smoothed), 32'(out_smoothed));
          check_field("window_low", 32'(want.window_low), 32'(out_window_low));
          check_field("window_high", 32'(want.window_high), 32'(out_window_high));
        end
        out_wait = calm_out ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= (hold_left > 0) || (out_wait > 0);
      if (hold_left > 0) hold_left--;
      else if (out_wait > 0 && (out_valid || $urandom_range(0, 1) == 1)) out_wait--;
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic queue_item(input logic mode, input logic [9:0] smp,
                            input logic [31:0] t);
    pulse_item_t it;
    it.mode    = mode;
    it.sample  = smp;
    it.time_ms = t;
    queued_items.push_back(it);
    item_total++;
    if (mode) gen_running = !gen_running;
  endtask

  // toggle with random don't-care fields
  task automatic queue_toggle();
    queue_item(1'b1, 10'($urandom_range(0, 1023)), $urandom);
  endtask

  // a sawtooth-like pulse: quick rise over a quarter period, slow fall
  task automatic queue_pulse_train(input int n);
    int          period, step, base, amp, rise, ph, val;
    logic [31:0] start, elapsed;
    period = $urandom_range(350, 1500);
    step   = $urandom_range(8, 40);
    base   = $urandom_range(0, 400);
    amp    = $urandom_range(200, 1023);
    rise   = period / 4;
    start  = gen_time;
    for (int k = 0; k < n; k++) begin
      elapsed = gen_time - start;
      ph = elapsed % period;
      if (ph < rise) val = base + amp * ph / rise;
      else val = base + amp - amp * (ph - rise) / (period - rise);
      val = val + $urandom_range(0, 8);
      if (val > 1023) val = 1023;
      queue_item(1'b0, 10'(val), gen_time);
      gen_time = gen_time + step;
    end
  endtask

  // mostly well-formed pulse trains, with noise, gaps, stops and wraps
  task automatic run_phase(input int count);
    int target, pick, n;
    target = item_total + count;
    while (item_total < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        if (!gen_running) queue_toggle();
        queue_pulse_train($urandom_range(10, 40));
      end else if (pick == 6) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          queue_item(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                     $urandom);
      end else if (pick == 7) begin
        // silence past the reset timeout
        gen_time = gen_time + $urandom_range(3001, 80000);
        if (!gen_running) queue_toggle();
        queue_pulse_train($urandom_range(5, 15));
      end else if (pick == 8) begin
        if (gen_running) queue_toggle();
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          queue_item(1'b0, 10'($urandom_range(0, 1023)), $urandom);
        queue_toggle();
      end else begin
        // timestamp near the wrap, which a train may cross
        gen_time = 32'hFFFF_FFFF - $urandom_range(0, 600);
        if (!gen_running) queue_toggle();
        queue_pulse_train($urandom_range(10, 30));
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ALPHA:     alpha_q    = val[16:0];
      REG_THRESHOLD: slope_thr  = val;
      REG_MIN_INT:   min_gap_ms = val[15:0];
      REG_MAX_INT:   max_gap_ms = val[15:0];
      REG_TIMEOUT:   stale_ms   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [17:0] a, input logic [17:0] thr,
                            input logic [17:0] mn, input logic [17:0] mx,
                            input logic [17:0] to);
    write_reg(REG_ALPHA, a);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MIN_INT, mn);
    write_reg(REG_MAX_INT, mx);
    write_reg(REG_TIMEOUT, to);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // block idle: nothing queued, offered or awaited
  task automatic settle();
    do @(negedge clk);
    while (queued_items.size() != 0 || awaited_reports.size() != 0 || in_valid);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    reset_detector();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: flat window, peak at time zero, limits and timeout
    queue_item(1'b0, 10'd512, 32'd5);
    queue_item(1'b1, 10'd0, 32'd0);
    queue_item(1'b0, 10'd1023, 32'd0);
    queue_item(1'b0, 10'd0, 32'd20);
    queue_item(1'b0, 10'd1023, 32'd700);
    queue_item(1'b0, 10'd0, 32'd720);
    queue_item(1'b0, 10'd1023, 32'd1500);
    queue_item(1'b0, 10'd0, 32'd1520);
    queue_item(1'b0, 10'd1023, 32'd1600);
    queue_item(1'b0, 10'd0, 32'd1620);
    queue_item(1'b0, 10'd1023, 32'd4000);
    queue_item(1'b0, 10'd0, 32'd7100);
    queue_item(1'b1, 10'd1023, 32'hFFFF_FFFF);
    queue_item(1'b0, 10'd1023, 32'hFFFF_FFFF);
    queue_item(1'b1, 10'd0, 32'd0);
    settle();

    // pass-through filter, open limits: wrap and rate saturation
    set_config(18'(ALPHA_ONE), 18'd0, 18'd0, 18'd65535, 18'd65535);
    queue_item(1'b0, 10'd0, 32'hFFFF_FFF0);
    queue_item(1'b0, 10'd1023, 32'hFFFF_FFF8);
    queue_item(1'b0, 10'd0, 32'hFFFF_FFF9);
    queue_item(1'b0, 10'd1023, 32'd2);
    queue_item(1'b0, 10'd0, 32'd3);
    queue_item(1'b0, 10'd1023, 32'd300);
    settle();

    // alpha above one, top threshold, zero timeout
    set_config(18'h1FFFF, 18'h3FFFF, 18'd300, 18'd2000, 18'd0);
    queue_item(1'b0, 10'd0, 32'd301);
    queue_item(1'b0, 10'd1023, 32'd302);
    settle();

    gen_time = $urandom;
    set_config(18'(ALPHA_RST), THRESHOLD_RST, 18'(MIN_INT_RST), 18'(MAX_INT_RST),
               18'(TIMEOUT_RST));
    run_phase(100);
    // receiver holds off while the sender keeps offering
    hold_toggle = ~hold_toggle;
    settle();

    set_config(18'($urandom_range(3000, 40000)), 18'($urandom_range(0, 3000)),
               18'($urandom_range(150, 400)), 18'($urandom_range(1200, 3000)),
               18'($urandom_range(1500, 6000)));
    run_phase(100);
    settle();

    set_config(18'(ALPHA_ONE), 18'd0, 18'd0, 18'd65535, 18'd65535);
    run_phase(100);
    settle();

    set_config(18'd0, 18'($urandom_range(0, 500)), 18'd0, 18'd65535, 18'd65535);
    run_phase(60);
    settle();

    set_config(18'($urandom_range(0, 131071)), 18'($urandom_range(0, 262143)),
               18'($urandom_range(0, 65535)), 18'($urandom_range(0, 65535)),
               18'($urandom_range(0, 65535)));
    run_phase(100);
    settle();

    set_config(18'(ALPHA_ONE), 18'h3FFFF, 18'd65535, 18'd0, 18'd0);
    run_phase(60);
    settle();

    set_config(18'($urandom_range(3000, 40000)), 18'($urandom_range(0, 3000)),
               18'($urandom_range(150, 400)), 18'($urandom_range(1200, 3000)),
               18'($urandom_range(1500, 6000)));
    run_phase(100);
    settle();

    repeat (200) @(posedge clk);
    if (errors == 0 && awaited_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/prd_pkg.sv
rtl/core/pulse_rate_detector.sv
tb/testbench.sv
